/* rtl/acss_pkg.sv */
// Shared types, constants and the millivolt scaling function for the ADC
// channel scan sequencer. Depends on nothing; the interface and sequencer files import it.
`timescale 1ns / 1ps

package acss_pkg;

    // field widths
    localparam int MODE_W    = 2;
    localparam int SAMPLE_W  = 12;
    localparam int MV_W      = 12;
    localparam int CHAN_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int ENABLE_W  = 16;
    localparam int POS_W     = 5;
    localparam int PROD_W    = SAMPLE_W + MV_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // scaling constants: mv = floor(sample * 3300 / 4095)
    localparam logic [MV_W-1:0]     MV_FULL_SCALE   = 12'd3300;
    localparam logic [SAMPLE_W:0]   CODE_FULL_SCALE = 13'd4095;
    localparam logic [POS_W-1:0]    POS_MAX         = 5'd31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 2'd1;

    // item modes
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_EOC   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_START = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } state_t;

    // one result beat
    typedef struct packed {
        logic              start_valid;
        logic [CHAN_W-1:0] start_channel;
        logic              sample_valid;
        logic [CHAN_W-1:0] sample_channel;
        logic [MV_W-1:0]   sample_mv;
        logic [MV_W-1:0]   read_mv;
        logic              ignored;
        logic              in_scan;
    } result_t;

    // floor(prod / 4095): prod = q*4096 + lo = q*4095 + (q + lo),
    // and q + lo stays below 2*4095, so one correction step suffices
    function automatic logic [MV_W-1:0] scale_div(input logic [PROD_W-1:0] prod);
        logic [MV_W-1:0]   q;
        logic [SAMPLE_W:0] r;
        q = prod[PROD_W-1:SAMPLE_W];
        r = {1'b0, prod[SAMPLE_W-1:0]} + {1'b0, q};
        return (r >= CODE_FULL_SCALE) ? q + 1'b1 : q;
    endfunction

endpackage

/* rtl/acss_if.sv */
// Valid/ready channel interfaces for the ADC channel scan sequencer:
// item input, result output and configuration write. Uses acss_pkg.
`timescale 1ns / 1ps

interface acss_item_if import acss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;

    modport source (output valid, output mode, output sample, output channel, input ready);
    modport sink   (input valid, input mode, input sample, input channel, output ready);
endinterface

interface acss_result_if import acss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              start_valid;
    logic [CHAN_W-1:0] start_channel;
    logic              sample_valid;
    logic [CHAN_W-1:0] sample_channel;
    logic [MV_W-1:0]   sample_mv;
    logic [MV_W-1:0]   read_mv;
    logic              ignored;
    logic              in_scan;

    modport source (
        output valid, output start_valid, output start_channel, output sample_valid,
        output sample_channel, output sample_mv, output read_mv, output ignored,
        output in_scan, input ready
    );
    modport sink (
        input valid, input start_valid, input start_channel, input sample_valid,
        input sample_channel, input sample_mv, input read_mv, input ignored,
        input in_scan, output ready
    );
endinterface

interface acss_cfg_if import acss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/acss_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
`timescale 1ns / 1ps

module acss_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/adc_channel_scan_sequencer.sv */
// ADC channel scan sequencer: a tick starts a scan at the lowest enabled
// channel below min(channel_count, NUM_CHANNELS, 16); each end of conversion
// scales the sample to millivolts (floor(sample*3300/4095)), stores it per
// channel and requests the next enabled channel until none is left. A single
// start converts one channel outside a scan; a read returns the stored value.
// One item is worked on at a time. The accepting cycle launches the millivolt
// table read. The next cycle registers the multiply and the channel search.
// The DONE state applies the scaling correction, writes the table back and
// loads the result register once the result side is free. Loading the result
// register frees the input side, so the next item is taken in the following
// cycle. A stalled result holds the block in its last step and blocks the
// input. The table comes up as zero through per-entry valid bits; no
// clearing pass is needed.
// Depends on acss_pkg, acss_if.sv and acss_ram.
`timescale 1ns / 1ps

module adc_channel_scan_sequencer import acss_pkg::*; #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    acss_cfg_if.sink          cfg,
    acss_item_if.sink         item,
    acss_result_if.source     result
);

    localparam int AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EW      = (AW > CHAN_W) ? AW : CHAN_W;
    localparam int LIM_CAP = (NUM_CHANNELS < ENABLE_W) ? NUM_CHANNELS : ENABLE_W;

    // control state
    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [ENABLE_W-1:0]  enable_reg;
    logic                 busy_reg, busy_next;
    logic                 scan_reg, scan_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CHAN_W-1:0]    cur_reg, cur_next;
    logic [NUM_CHANNELS-1:0] written_reg;
    logic                 out_valid_reg;

    // item payload and datapath registers
    mode_t                mode_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [CHAN_W-1:0]    chan_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 found_reg, found_next;
    logic [CHAN_W-1:0]    found_idx_reg, found_idx_next;
    result_t              out_reg, res_next;

    // control strobes
    logic                 accept;
    logic                 out_free;
    logic                 commit;

    // table port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [MV_W-1:0]      ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [MV_W-1:0]      ram_rdata;

    // address and range helpers
    logic [EW-1:0]        in_chan_ext, chan_ext, cur_ext;
    logic [AW-1:0]        chan_addr, cur_addr;
    logic                 chan_in_range, cur_in_range;

    // search helpers
    logic [COUNT_W-1:0]   lim;
    logic [POS_W-1:0]     search_start;
    logic [MV_W-1:0]      mv;

    assign in_chan_ext   = EW'(item.channel);
    assign chan_ext      = EW'(chan_reg);
    assign cur_ext       = EW'(cur_reg);
    assign chan_addr     = chan_ext[AW-1:0];
    assign cur_addr      = cur_ext[AW-1:0];
    assign chan_in_range = int'(chan_reg) < NUM_CHANNELS;
    assign cur_in_range  = int'(cur_reg) < NUM_CHANNELS;
    assign ram_raddr     = in_chan_ext[AW-1:0];
    assign mv            = scale_div(prod_reg);

    // configuration writes, always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            enable_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CHANNEL_COUNT:  count_reg  <= cfg.data[COUNT_W-1:0];
                REG_CHANNEL_ENABLE: enable_reg <= cfg.data[ENABLE_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (item.valid) state_next = S_CALC;
            S_CALC: state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        item.ready = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            S_IDLE: item.ready = 1'b1;
            S_CALC: ;
            S_DONE: commit = out_free;
            default: ;
        endcase
    end

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // search limit: smallest of channel count, store depth and enable width
    always_comb
    begin
        if (int'(count_reg) > LIM_CAP)
        begin
            lim = COUNT_W'(LIM_CAP);
        end
        else
        begin
            lim = count_reg;
        end
    end

    // lowest enabled channel at or above the start position
    always_comb
    begin
        if (mode_reg == MODE_TICK)
        begin
            search_start = '0;
        end
        else if (pos_reg == POS_MAX)
        begin
            search_start = POS_MAX;
        end
        else
        begin
            search_start = pos_reg + 1'b1;
        end
        found_next     = 1'b0;
        found_idx_next = '0;
        for (int i = ENABLE_W - 1; i >= 0; i--)
        begin
            if (enable_reg[i] && (i >= int'(search_start)) && (i < int'(lim)))
            begin
                found_next     = 1'b1;
                found_idx_next = CHAN_W'(i);
            end
        end
    end

    // item capture, multiply and search registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode_t'(item.mode);
            sample_reg <= item.sample;
            chan_reg   <= item.channel;
        end
        if (state_reg == S_CALC)
        begin
            prod_reg      <= PROD_W'(sample_reg) * PROD_W'(MV_FULL_SCALE);
            found_reg     <= found_next;
            found_idx_reg <= found_idx_next;
        end
    end

    // commit: result and next sequencer state
    always_comb
    begin
        res_next  = '0;
        busy_next = busy_reg;
        scan_next = scan_reg;
        pos_next  = pos_reg;
        cur_next  = cur_reg;
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = mv;
        unique case (mode_reg)
            MODE_TICK:
            begin
                if (!scan_reg && !busy_reg)
                begin
                    pos_next = '0;
                    if (found_reg)
                    begin
                        res_next.start_valid   = 1'b1;
                        res_next.start_channel = found_idx_reg;
                        busy_next              = 1'b1;
                        cur_next               = found_idx_reg;
                        scan_next              = 1'b1;
                        pos_next               = POS_W'(found_idx_reg);
                    end
                end
            end
            MODE_EOC:
            begin
                if (!busy_reg)
                begin
                    res_next.ignored = 1'b1;
                end
                else
                begin
                    ram_we                  = commit && cur_in_range;
                    res_next.sample_valid   = 1'b1;
                    res_next.sample_channel = cur_reg;
                    res_next.sample_mv      = mv;
                    busy_next               = 1'b0;
                    if (scan_reg)
                    begin
                        if (found_reg)
                        begin
                            res_next.start_valid   = 1'b1;
                            res_next.start_channel = found_idx_reg;
                            busy_next              = 1'b1;
                            cur_next               = found_idx_reg;
                            pos_next               = POS_W'(found_idx_reg);
                        end
                        else
                        begin
                            scan_next = 1'b0;
                        end
                    end
                end
            end
            MODE_READ:
            begin
                if (chan_in_range && written_reg[chan_addr])
                begin
                    res_next.read_mv = ram_rdata;
                end
            end
            MODE_START:
            begin
                if (busy_reg)
                begin
                    res_next.ignored = 1'b1;
                end
                else
                begin
                    res_next.start_valid   = 1'b1;
                    res_next.start_channel = chan_reg;
                    busy_next              = 1'b1;
                    cur_next               = chan_reg;
                end
            end
            default: ;
        endcase
        res_next.in_scan = scan_next;
    end

    // sequencer state and written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            scan_reg    <= 1'b0;
            pos_reg     <= '0;
            cur_reg     <= '0;
            written_reg <= '0;
        end
        else if (commit)
        begin
            busy_reg <= busy_next;
            scan_reg <= scan_next;
            pos_reg  <= pos_next;
            cur_reg  <= cur_next;
            if (ram_we)
            begin
                written_reg[cur_addr] <= 1'b1;
            end
        end
    end

    // millivolt table, read on acceptance
    acss_ram #(
        .WIDTH (MV_W),
        .DEPTH (NUM_CHANNELS)
    ) u_mv_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_reg <= res_next;
        end
    end

    // result beat
    assign result.valid          = out_valid_reg;
    assign result.start_valid    = out_reg.start_valid;
    assign result.start_channel  = out_reg.start_channel;
    assign result.sample_valid   = out_reg.sample_valid;
    assign result.sample_channel = out_reg.sample_channel;
    assign result.sample_mv      = out_reg.sample_mv;
    assign result.read_mv        = out_reg.read_mv;
    assign result.ignored        = out_reg.ignored;
    assign result.in_scan        = out_reg.in_scan;

endmodule
